// ===== hdl/ucs_pkg.sv =====
// shared types and codes for the uri component scanner
`default_nettype none

package ucs_pkg;

  localparam int ByteW = 8;
  localparam int PartW = 2;

  // part codes as they appear on the result channel
  localparam logic [PartW-1:0] PART_SCHEME   = 2'd0;
  localparam logic [PartW-1:0] PART_RESOURCE = 2'd1;
  localparam logic [PartW-1:0] PART_QUERY    = 2'd2;
  localparam logic [PartW-1:0] PART_TAIL     = 2'd3;

  typedef enum logic [3:0] {
    PH_SCHEME   = 4'b0001,
    PH_RESOURCE = 4'b0010,
    PH_QUERY    = 4'b0100,
    PH_TAIL     = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   failed;
  } scan_state_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic [PartW-1:0] part;
    logic             is_separator;
    logic             error;
    logic             last_out;
    logic             uri_valid;
  } scan_result_t;

endpackage

`default_nettype wire

// ===== hdl/ucs_if.sv =====
// valid/ready channels for uri bytes and tagged results
`default_nettype none

interface ucs_in_if;
  import ucs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;
  logic             last_in;

  modport source (output valid, output byte_in, output last_in, input ready);
  modport sink (input valid, input byte_in, input last_in, output ready);
endinterface

interface ucs_out_if;
  import ucs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_out;
  logic [PartW-1:0] part;
  logic             is_separator;
  logic             error;
  logic             last_out;
  logic             uri_valid;

  modport source (output valid, output byte_out, output part, output is_separator,
                  output error, output last_out, output uri_valid, input ready);
  modport sink (input valid, input byte_out, input part, input is_separator,
                input error, input last_out, input uri_valid, output ready);
endinterface

`default_nettype wire

// ===== hdl/ucs_step.sv =====
// per-byte classification and phase/error update
`default_nettype none

module ucs_step
  import ucs_pkg::*;
(
  input  wire logic [ByteW-1:0] byte_c,
  input  wire logic             last,
  input  wire scan_state_t      state,
  output scan_result_t          res,
  output scan_state_t           state_next
);

  localparam logic [ByteW-1:0] CH_COLON = 8'h3a;
  localparam logic [ByteW-1:0] CH_QMARK = 8'h3f;
  localparam logic [ByteW-1:0] CH_HASH  = 8'h23;
  localparam logic [ByteW-1:0] CH_TILDE = 8'h7e;
  localparam logic [ByteW-1:0] CH_PCT   = 8'h25;
  localparam logic [ByteW-1:0] CH_AMP   = 8'h26;
  localparam logic [ByteW-1:0] CH_EQ    = 8'h3d;
  localparam logic [ByteW-1:0] CH_SLASH = 8'h2f;
  localparam logic [ByteW-1:0] CH_DASH  = 8'h2d;
  localparam logic [ByteW-1:0] CH_UNDER = 8'h5f;
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2e;

  logic             plain_ok;
  logic             query_ok;
  logic             ok;
  logic [ByteW-1:0] mark;
  logic [PartW-1:0] part;
  phase_t           adv;
  logic             checking;
  logic             sep;
  logic             fail_now;
  logic             failed_upd;
  phase_t           phase_upd;

  assign plain_ok = (byte_c >= 8'h41 && byte_c <= 8'h5a) ||
                    (byte_c >= 8'h61 && byte_c <= 8'h7a) ||
                    (byte_c >= 8'h30 && byte_c <= 8'h39) ||
                    byte_c == CH_DASH || byte_c == CH_UNDER ||
                    byte_c == CH_DOT || byte_c == CH_TILDE;
  assign query_ok = plain_ok || byte_c == CH_COLON || byte_c == CH_AMP ||
                    byte_c == CH_EQ || byte_c == CH_SLASH || byte_c == CH_PCT;

  always_comb begin
    case (state.phase)
      PH_SCHEME: begin
        part = PART_SCHEME;
        ok   = plain_ok;
        mark = CH_COLON;
        adv  = PH_RESOURCE;
      end
      PH_RESOURCE: begin
        part = PART_RESOURCE;
        ok   = plain_ok;
        mark = CH_QMARK;
        adv  = PH_QUERY;
      end
      PH_QUERY: begin
        part = PART_QUERY;
        ok   = query_ok;
        mark = CH_HASH;
        adv  = PH_TAIL;
      end
      PH_TAIL: begin
        part = PART_TAIL;
        ok   = 1'b1;
        mark = CH_HASH;
        adv  = PH_TAIL;
      end
      default: begin
        part = PART_SCHEME;
        ok   = plain_ok;
        mark = CH_COLON;
        adv  = PH_RESOURCE;
      end
    endcase
  end

  // after an error or past the fragment mark nothing is checked
  assign checking   = !state.failed && state.phase != PH_TAIL;
  assign sep        = checking && !ok && byte_c == mark;
  assign fail_now   = checking && !ok && byte_c != mark;
  assign failed_upd = state.failed | fail_now;
  assign phase_upd  = sep ? adv : state.phase;

  assign res.byte_out     = byte_c;
  assign res.part         = part;
  assign res.is_separator = sep;
  assign res.error        = failed_upd;
  assign res.last_out     = last;
  assign res.uri_valid    = last & ~failed_upd;

  assign state_next.phase  = last ? PH_SCHEME : phase_upd;
  assign state_next.failed = last ? 1'b0 : failed_upd;

endmodule

`default_nettype wire

// ===== hdl/uri_component_scanner_top.sv =====
// uri component scanner: input register, per-byte tagging, result register
// data path: an accepted byte is held in the input register, then its tagged result in the result register
// throughput: one byte per cycle, sustained while the result side keeps up
// the per-byte character-class compare sits between the input and result registers
// reset: clears both register valids, phase returns to scheme, error flag cleared
`default_nettype none

module uri_component_scanner_top
  import ucs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  ucs_in_if.sink    scan_in,
  ucs_out_if.source scan_out
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_last;
  logic             out_valid;
  scan_result_t     res;
  scan_result_t     res_next;
  scan_state_t      state;
  scan_state_t      state_next;
  logic             out_load;
  logic             in_take;

  assign out_load      = s1_valid && (!out_valid || scan_out.ready);
  assign scan_in.ready = !s1_valid || out_load;
  assign in_take       = scan_in.valid && scan_in.ready;

  ucs_step u_step (
    .byte_c     (s1_byte),
    .last       (s1_last),
    .state      (state),
    .res        (res_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      state.phase  <= PH_SCHEME;
      state.failed <= 1'b0;
    end else begin
      if (scan_in.ready) begin
        s1_valid <= scan_in.valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (scan_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= scan_in.byte_in;
      s1_last <= scan_in.last_in;
    end
    if (out_load) begin
      res <= res_next;
    end
  end

  assign scan_out.valid        = out_valid;
  assign scan_out.byte_out     = res.byte_out;
  assign scan_out.part         = res.part;
  assign scan_out.is_separator = res.is_separator;
  assign scan_out.error        = res.error;
  assign scan_out.last_out     = res.last_out;
  assign scan_out.uri_valid    = res.uri_valid;

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state.phase))
    else $error("phase register not one-hot");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    out_load && s1_last |=> state.phase == PH_SCHEME && !state.failed)
    else $error("scanner did not restart after last byte");

  a_sep_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.is_separator |-> !res.error && res.part != PART_TAIL)
    else $error("separator tagged with error or in tail");

  a_valid_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.uri_valid |-> res.last_out && !res.error)
    else $error("uri_valid outside a clean last byte");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_load && state.failed |-> res_next.error && !res_next.is_separator)
    else $error("error flag dropped within a uri");

endmodule

`default_nettype wire
